// File: hdl/trq_pkg.sv
// Shared types, widths and codes for the time-ordered release queue.
// Used by the controller, the datapath, the top level and the checker.
package trq_pkg;

  localparam int unsigned KindW     = 3;
  localparam int unsigned TypeW     = 8;
  localparam int unsigned TimeW     = 20;
  localparam int unsigned DelayW    = 12;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned PosW      = 6;
  localparam int unsigned OccW      = 7;

  // One tick releases at most this many entries.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned TickCntW   = $clog2(MaxResults);

  typedef logic [KindW-1:0]   kind_t;
  typedef logic [TypeW-1:0]   type_id_t;
  typedef logic [TimeW-1:0]   minute_t;
  typedef logic [DelayW-1:0]  delay_t;
  typedef logic [StatusW-1:0] status_t;

  localparam kind_t KIND_INS_DELAY = 3'd0;
  localparam kind_t KIND_INS_AT    = 3'd1;
  localparam kind_t KIND_REMOVE    = 3'd2;
  localparam kind_t KIND_QUERY     = 3'd3;
  localparam kind_t KIND_TICK      = 3'd4;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_REMOVED   = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_RELEASED  = 3'd4;
  localparam status_t ST_NONE_DUE  = 3'd5;
  localparam status_t ST_FOUND     = 3'd6;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LATCH,
    CMD_EVAL,
    CMD_EXEC,
    CMD_POP,
    CMD_NONE_DUE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   pop_last;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  head_due;
    logic  next_due;
  } dp_stat_t;

endpackage

// File: hdl/time_ordered_release_queue.sv
// Top level of the time-ordered release queue: joins the controller and the datapath.
// Depends on trq_pkg, trq_ctl and trq_dp.
//
// Holds up to DEPTH entries of (type, release minute) in order of release minute, equal
// minutes in arrival order, in a register array that shifts on each insert, remove or
// release. An accepted item is captured, compared against every entry and then used to update
// the array and the output register, the update waiting while the output is stalled; insert,
// remove and query give one result each. A tick then releases one due entry per cycle while
// the output is not stalled, at most 16 per tick, or gives one "nothing due" result. The next
// item is taken once the last result of the previous one is in the output register, so a
// waiting result does not hold back the input. Kinds 5 to 7 are taken and ignored. After
// reset the queue is empty and usable at once.
module time_ordered_release_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [trq_pkg::KindW-1:0]    in_kind,
  input  logic [trq_pkg::TypeW-1:0]    in_type_id,
  input  logic [trq_pkg::TimeW-1:0]    in_time_value,
  input  logic [trq_pkg::DelayW-1:0]   in_delay_minutes,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [trq_pkg::StatusW-1:0]  out_status,
  output logic [trq_pkg::TypeW-1:0]    out_item_type,
  output logic [trq_pkg::TimeW-1:0]    out_item_due_time,
  output logic [trq_pkg::PosW-1:0]     out_position,
  output logic [trq_pkg::OccW-1:0]     out_occupancy,
  output logic                         out_last
);
  import trq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  trq_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  trq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_type_id        (in_type_id),
    .in_time_value     (in_time_value),
    .in_delay_minutes  (in_delay_minutes),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_status),
    .out_item_type     (out_item_type),
    .out_item_due_time (out_item_due_time),
    .out_position      (out_position),
    .out_occupancy     (out_occupancy),
    .out_last          (out_last)
  );

endmodule

// File: hdl/trq_dp.sv
// Datapath of the release queue: the sorted entry array, the held item and the result register.
// Depends on trq_pkg; driven by commands from trq_ctl.
module trq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [trq_pkg::KindW-1:0]    in_kind,
  input  logic [trq_pkg::TypeW-1:0]    in_type_id,
  input  logic [trq_pkg::TimeW-1:0]    in_time_value,
  input  logic [trq_pkg::DelayW-1:0]   in_delay_minutes,
  input  trq_pkg::ctl_cmd_t            cmd,
  output trq_pkg::dp_stat_t            stat,
  output logic [trq_pkg::StatusW-1:0]  out_status,
  output logic [trq_pkg::TypeW-1:0]    out_item_type,
  output logic [trq_pkg::TimeW-1:0]    out_item_due_time,
  output logic [trq_pkg::PosW-1:0]     out_position,
  output logic [trq_pkg::OccW-1:0]     out_occupancy,
  output logic                         out_last
);
  import trq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  kind_t             kind_r, kind_nxt;
  type_id_t          type_r, type_nxt;
  minute_t           tv_r, tv_nxt;
  delay_t            dly_r, dly_nxt;
  minute_t           due_r, due_nxt;
  logic [DEPTH-1:0]  match_r, match_nxt;
  type_id_t          slot_type_r [DEPTH];
  type_id_t          slot_type_nxt [DEPTH];
  minute_t           slot_due_r [DEPTH];
  minute_t           slot_due_nxt [DEPTH];
  logic [CntW-1:0]   count_r, count_nxt;

  status_t           res_status_r, res_status_nxt;
  type_id_t          res_type_r, res_type_nxt;
  minute_t           res_due_r, res_due_nxt;
  logic [PosW-1:0]   res_pos_r, res_pos_nxt;
  logic [OccW-1:0]   res_occ_r, res_occ_nxt;
  logic              res_last_r, res_last_nxt;

  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  le;
  logic [DEPTH-1:0]  sfx;
  logic [IdxW-1:0]   qpos;
  logic              hit;
  logic              full;
  logic [TimeW:0]    due_sum;
  minute_t           due_calc;
  logic              load;

  // Per-entry compares; sfx and qpos also look at the matches of the other entries.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CntW'(i) < count_r;
      le[i]    = valid[i] && (slot_due_r[i] <= due_r);
      sfx[i]   = |(match_r >> (i + 1));
    end
    qpos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_r[i] && !(|(match_r & ((DEPTH'(1) << i) - DEPTH'(1))))) begin
        qpos = qpos | IdxW'(i);
      end
    end
  end

  assign hit  = |match_r;
  assign full = (count_r == CntW'(DEPTH));

  assign due_sum  = {1'b0, tv_r} + (TimeW + 1)'(dly_r) + (TimeW + 1)'(1);
  assign due_calc = due_sum[TimeW] ? '1 : due_sum[TimeW-1:0];

  assign stat.kind     = kind_r;
  assign stat.head_due = (count_r != '0) && (slot_due_r[0] <= tv_r);
  assign stat.next_due = (count_r > CntW'(1)) && (slot_due_r[1] <= tv_r);

  always_comb begin
    kind_nxt       = kind_r;
    type_nxt       = type_r;
    tv_nxt         = tv_r;
    dly_nxt        = dly_r;
    due_nxt        = due_r;
    match_nxt      = match_r;
    slot_type_nxt  = slot_type_r;
    slot_due_nxt   = slot_due_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_type_nxt   = res_type_r;
    res_due_nxt    = res_due_r;
    res_pos_nxt    = res_pos_r;
    res_occ_nxt    = res_occ_r;
    res_last_nxt   = res_last_r;
    load           = 1'b0;

    unique case (cmd.op)
      CMD_LATCH: begin
        kind_nxt = in_kind;
        type_nxt = in_type_id;
        tv_nxt   = in_time_value;
        dly_nxt  = in_delay_minutes;
      end
      CMD_EVAL: begin
        due_nxt = (kind_r == KIND_INS_DELAY) ? due_calc : tv_r;
        for (int i = 0; i < DEPTH; i++) begin
          match_nxt[i] = valid[i] && (slot_type_r[i] == type_r);
        end
      end
      CMD_EXEC: begin
        load         = 1'b1;
        res_type_nxt = '0;
        res_due_nxt  = '0;
        res_pos_nxt  = '0;
        res_last_nxt = 1'b1;
        unique case (kind_r)
          KIND_INS_DELAY, KIND_INS_AT: begin
            res_due_nxt = due_r;
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              res_status_nxt = ST_INSERTED;
              count_nxt      = count_r + CntW'(1);
              // The new entry goes after every entry due at or before it.
              if (!le[0]) begin
                slot_type_nxt[0] = type_r;
                slot_due_nxt[0]  = due_r;
              end
              for (int i = 1; i < DEPTH; i++) begin
                if (!le[i]) begin
                  if (le[i-1]) begin
                    slot_type_nxt[i] = type_r;
                    slot_due_nxt[i]  = due_r;
                  end else begin
                    slot_type_nxt[i] = slot_type_r[i-1];
                    slot_due_nxt[i]  = slot_due_r[i-1];
                  end
                end
              end
            end
          end
          KIND_REMOVE: begin
            if (hit) begin
              res_status_nxt = ST_REMOVED;
              count_nxt      = count_r - CntW'(1);
              // Entries from the last match upwards close the gap.
              for (int i = 0; i < DEPTH - 1; i++) begin
                if (!sfx[i]) begin
                  slot_type_nxt[i] = slot_type_r[i+1];
                  slot_due_nxt[i]  = slot_due_r[i+1];
                end
              end
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          KIND_QUERY: begin
            if (hit) begin
              res_status_nxt = ST_FOUND;
              res_pos_nxt    = PosW'(qpos);
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          default: begin
            res_status_nxt = ST_NONE_DUE;
          end
        endcase
      end
      CMD_POP: begin
        load           = 1'b1;
        res_status_nxt = ST_RELEASED;
        res_type_nxt   = slot_type_r[0];
        res_due_nxt    = slot_due_r[0];
        res_pos_nxt    = '0;
        res_last_nxt   = cmd.pop_last;
        count_nxt      = count_r - CntW'(1);
        for (int i = 0; i < DEPTH - 1; i++) begin
          slot_type_nxt[i] = slot_type_r[i+1];
          slot_due_nxt[i]  = slot_due_r[i+1];
        end
      end
      CMD_NONE_DUE: begin
        load           = 1'b1;
        res_status_nxt = ST_NONE_DUE;
        res_type_nxt   = '0;
        res_due_nxt    = '0;
        res_pos_nxt    = '0;
        res_last_nxt   = 1'b1;
      end
      default: begin
      end
    endcase

    if (load) begin
      res_occ_nxt = OccW'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    type_r       <= type_nxt;
    tv_r         <= tv_nxt;
    dly_r        <= dly_nxt;
    due_r        <= due_nxt;
    match_r      <= match_nxt;
    slot_type_r  <= slot_type_nxt;
    slot_due_r   <= slot_due_nxt;
    res_status_r <= res_status_nxt;
    res_type_r   <= res_type_nxt;
    res_due_r    <= res_due_nxt;
    res_pos_r    <= res_pos_nxt;
    res_occ_r    <= res_occ_nxt;
    res_last_r   <= res_last_nxt;
  end

  assign out_status        = res_status_r;
  assign out_item_type     = res_type_r;
  assign out_item_due_time = res_due_r;
  assign out_position      = res_pos_r;
  assign out_occupancy     = res_occ_r;
  assign out_last          = res_last_r;

endmodule

// File: hdl/trq_ctl.sv
// Controller of the release queue: sequences each item and owns both handshakes.
// Depends on trq_pkg; commands the datapath trq_dp.
module trq_ctl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [trq_pkg::KindW-1:0] in_kind,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  trq_pkg::dp_stat_t         stat,
  output trq_pkg::ctl_cmd_t         cmd
);
  import trq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_TICK = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TickCntW-1:0] n_r, n_nxt;
  logic                out_free;
  logic                load;
  logic                final_pop;

  // The result register may be refilled in the cycle its item is taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign final_pop = !stat.next_due || (n_r == TickCntW'(MaxResults - 1));
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    cmd.op       = CMD_IDLE;
    cmd.pop_last = 1'b0;
    load         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = CMD_LATCH;
          if (in_kind <= KIND_TICK) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd.op    = CMD_EVAL;
        n_nxt     = '0;
        state_nxt = (stat.kind == KIND_TICK) ? S_TICK : S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.op    = CMD_EXEC;
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          load = 1'b1;
          if (stat.head_due) begin
            cmd.op       = CMD_POP;
            cmd.pop_last = final_pop;
            n_nxt        = n_r + TickCntW'(1);
            if (final_pop) begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.op    = CMD_NONE_DUE;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

endmodule

// File: hdl/trq_chk.sv
// Port-level checker for the time-ordered release queue, bound to the top level.
// Depends on trq_pkg; sees only the ports of time_ordered_release_queue.
module trq_chk #(
  parameter int unsigned DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [trq_pkg::KindW-1:0]    in_kind,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [trq_pkg::StatusW-1:0]  out_status,
  input logic [trq_pkg::TypeW-1:0]    out_item_type,
  input logic [trq_pkg::TimeW-1:0]    out_item_due_time,
  input logic [trq_pkg::PosW-1:0]     out_position,
  input logic [trq_pkg::OccW-1:0]     out_occupancy,
  input logic                         out_last
);
  import trq_pkg::*;

  // A result that is held back must stay put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_item_type)
      && $stable(out_item_due_time) && $stable(out_position) && $stable(out_occupancy)
      && $stable(out_last))
    else $error("stalled result changed");

  // An item of a defined kind keeps the input closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind <= KIND_TICK) |=> in_stall)
    else $error("input reopened before the item was processed");

  // The queue never reports more entries than it can hold.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= OccW'(DEPTH))
    else $error("occupancy beyond depth");

  // Only a released entry can be followed by further results of the same item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_RELEASED) |-> out_last)
    else $error("single-result item without last flag");

  // A successful insert leaves at least one entry held.
  a_insert_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INSERTED) |-> out_occupancy != '0)
    else $error("insert reported an empty queue");

endmodule

bind time_ordered_release_queue trq_chk #(.DEPTH(DEPTH)) u_trq_chk (.*);
